// ===== rtl/drik_pkg.sv =====
// Shared types, constants and arithmetic helpers of the delta robot inverse kinematics block.
package drik_pkg;

  localparam int ANG_BITS = 24;
  localparam int NB = 52;
  localparam int CORDIC_N = 24;
  localparam int LAT_ARM = 7 + NB + 8 + 3 + CORDIC_N + 1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNREACH = 2'd1;
  localparam logic [1:0] ST_ZERO    = 2'd2;

  localparam logic [1:0] REG_BASE_SIDE     = 2'd0;
  localparam logic [1:0] REG_EFFECTOR_SIDE = 2'd1;
  localparam logic [1:0] REG_UPPER_ARM     = 2'd2;
  localparam logic [1:0] REG_FOREARM       = 2'd3;

  localparam logic [15:0] RST_BASE_SIDE     = 16'd7317;
  localparam logic [15:0] RST_EFFECTOR_SIDE = 16'd1840;
  localparam logic [15:0] RST_UPPER_ARM     = 16'd1792;
  localparam logic [15:0] RST_FOREARM       = 16'd3712;

  localparam logic [23:0] SIN120_Q24     = 24'd14529495;
  localparam logic [23:0] HALF_TAN30_Q24 = 24'd4843165;

  typedef logic signed [27:0]  crd_t;
  typedef logic signed [63:0]  nar_t;
  typedef logic signed [127:0] wid_t;
  typedef logic signed [27:0]  ang_t;
  typedef logic [5:0][63:0]    parts_t;

  localparam ang_t PI_ANG = 28'sd52707179;

  typedef struct packed {
    logic neg;
    parts_t p;
  } mul_t;

  typedef struct packed {
    crd_t e_off;
    crd_t y1;
    crd_t y1x2;
    nar_t kc;
    nar_t r4;
  } cfg_k_t;

  // first half of a wide signed product: magnitudes split into 32-bit partial products
  function automatic mul_t mul_start(wid_t a, wid_t b);
    logic [127:0] ma;
    logic [127:0] mb;
    mul_t r;
    ma = a[127] ? 128'(-a) : 128'(a);
    mb = b[127] ? 128'(-b) : 128'(b);
    r.neg = a[127] ^ b[127];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 2; j++) begin
        r.p[i*2+j] = ma[32*i +: 32] * mb[32*j +: 32];
      end
    end
    return r;
  endfunction

  // second half: align, sum and apply the sign
  function automatic wid_t mul_finish(mul_t m);
    logic [191:0] acc;
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 2; j++) begin
        acc = acc + ({128'b0, m.p[i*2+j]} << (32 * (i + j)));
      end
    end
    return m.neg ? -wid_t'(acc[127:0]) : wid_t'(acc[127:0]);
  endfunction

  function automatic ang_t atan_step(int i);
    case (i)
      0:  return 28'sd13176795;
      1:  return 28'sd7778716;
      2:  return 28'sd4110060;
      3:  return 28'sd2086331;
      4:  return 28'sd1047214;
      5:  return 28'sd524117;
      6:  return 28'sd262123;
      7:  return 28'sd131069;
      8:  return 28'sd65536;
      9:  return 28'sd32768;
      10: return 28'sd16384;
      11: return 28'sd8192;
      12: return 28'sd4096;
      13: return 28'sd2048;
      14: return 28'sd1024;
      15: return 28'sd512;
      16: return 28'sd256;
      17: return 28'sd128;
      18: return 28'sd64;
      19: return 28'sd32;
      20: return 28'sd16;
      21: return 28'sd8;
      22: return 28'sd4;
      23: return 28'sd2;
      default: return '0;
    endcase
  endfunction

endpackage

// ===== rtl/drik_arm.sv =====
// One arm solver: sphere/circle intersection, pipelined square root and CORDIC arctangent.
module drik_arm #(
  parameter int ANGLE_FRAC_BITS = 14
) (
  input  logic                 clk,
  input  drik_pkg::crd_t       xa_in,
  input  drik_pkg::crd_t       ya_in,
  input  drik_pkg::crd_t       z_in,
  input  drik_pkg::cfg_k_t     cfg,
  output logic signed [16:0]   angle,
  output logic                 unreach
);
  import drik_pkg::*;

  localparam int RND_SH = ANG_BITS - ANGLE_FRAC_BITS;
  localparam int CW = 34;

  typedef struct packed {
    logic        fail;
    wid_t        pa;
    wid_t        sq;
    wid_t        m;
    crd_t        u;
    logic [23:0] az;
    logic        zpos;
  } side_t;

  typedef struct packed {
    logic fail;
    logic zero;
    logic nneg;
    logic mneg;
  } flag_t;

  // S1..S4: frame offset, squares, sums
  crd_t xa1, ya1, z1;
  crd_t u2;
  nar_t xx2, yy2, zz2;
  logic [23:0] az2;
  logic zpos2;
  nar_t s3, uu3, uy3, zz3;
  crd_t u3;
  logic [23:0] az3;
  logic zpos3;
  nar_t q4, p4, s4, zz4;
  crd_t u4;
  logic [23:0] az4;
  logic zpos4;

  always_ff @(posedge clk) begin
    xa1 <= xa_in;
    ya1 <= ya_in - cfg.e_off;
    z1 <= z_in;

    u2 <= cfg.y1 - ya1;
    xx2 <= nar_t'(xa1) * nar_t'(xa1);
    yy2 <= nar_t'(ya1) * nar_t'(ya1);
    zz2 <= nar_t'(z1) * nar_t'(z1);
    az2 <= z1[27] ? 24'(-z1) : 24'(z1);
    zpos2 <= !z1[27] && (z1 != '0);

    s3 <= xx2 + yy2 + zz2 + cfg.kc;
    uu3 <= nar_t'(u2) * nar_t'(u2);
    uy3 <= nar_t'(u2) * nar_t'(cfg.y1);
    zz3 <= zz2;
    u3 <= u2;
    az3 <= az2;
    zpos3 <= zpos2;

    q4 <= uu3 + zz3;
    p4 <= s3 + (uy3 <<< 1);
    s4 <= s3;
    zz4 <= zz3;
    u4 <= u3;
    az4 <= az3;
    zpos4 <= zpos3;
  end

  // S5/S6: wide products, S7: discriminant
  mul_t t1m, t2m, ym, sum, sqm, pmm;
  crd_t u5, u6;
  logic [23:0] az5, az6;
  logic zpos5, zpos6;
  wid_t t1_6, t2_6, y6, su6, sq6, pm6;
  wid_t d4_c;

  always_ff @(posedge clk) begin
    t1m <= mul_start(wid_t'(q4), wid_t'(cfg.r4));
    t2m <= mul_start(wid_t'(p4), wid_t'(p4));
    ym <= mul_start(wid_t'(zz4), wid_t'(cfg.y1x2));
    sum <= mul_start(wid_t'(s4), wid_t'(u4));
    sqm <= mul_start(wid_t'(s4), wid_t'(q4));
    pmm <= mul_start(wid_t'(q4), wid_t'(cfg.y1x2));
    u5 <= u4;
    az5 <= az4;
    zpos5 <= zpos4;

    t1_6 <= mul_finish(t1m);
    t2_6 <= mul_finish(t2m);
    y6 <= mul_finish(ym);
    su6 <= mul_finish(sum);
    sq6 <= mul_finish(sqm);
    pm6 <= mul_finish(pmm);
    u6 <= u5;
    az6 <= az5;
    zpos6 <= zpos5;
  end

  assign d4_c = t1_6 - t2_6;

  // square root, one result bit per stage
  logic [2*NB-1:0] rad  [NB+1];
  logic [NB+3:0]   rem  [NB+1];
  logic [NB-1:0]   root [NB+1];
  side_t           sd   [NB+1];

  always_ff @(posedge clk) begin
    rad[0] <= d4_c[2*NB-1:0];
    rem[0] <= '0;
    root[0] <= '0;
    sd[0] <= '{fail: d4_c[127], pa: y6 - su6, sq: sq6, m: pm6, u: u6, az: az6, zpos: zpos6};
  end

  for (genvar k = 0; k < NB; k++) begin : g_sqrt
    logic [NB+3:0] rsh, trial;
    assign rsh = {rem[k][NB+1:0], rad[k][2*NB-1 -: 2]};
    assign trial = {2'b00, root[k], 2'b01};
    always_ff @(posedge clk) begin
      sd[k+1] <= sd[k];
      rad[k+1] <= {rad[k][2*NB-3:0], 2'b00};
      if (rsh >= trial) begin
        rem[k+1] <= rsh - trial;
        root[k+1] <= {root[k][NB-2:0], 1'b1};
      end else begin
        rem[k+1] <= rsh;
        root[k+1] <= {root[k][NB-2:0], 1'b0};
      end
    end
  end

  // P1..P8: y2, g, m2, denominator
  mul_t am, um, dm;
  side_t sd1, sd2, sd3, sd4, sd5;
  wid_t asq2, y2_3, y2_4, y2_5, yu5, g6, m2_6, gabs7;
  logic [23:0] az_6;
  logic zpos_6, fail6;
  flag_t fl7, fl8, fl9, fl10;
  logic [111:0] den8, num8, den9, num9, den10, num10;

  always_ff @(posedge clk) begin
    am <= mul_start(wid_t'(root[NB]), wid_t'(sd[NB].az));
    sd1 <= sd[NB];

    asq2 <= mul_finish(am);
    sd2 <= sd1;

    y2_3 <= sd2.pa - asq2;
    sd3 <= sd2;

    um <= mul_start(y2_3, wid_t'(sd3.u));
    y2_4 <= y2_3;
    sd4 <= sd3;

    yu5 <= mul_finish(um);
    y2_5 <= y2_4;
    sd5 <= sd4;

    g6 <= sd5.sq + yu5;
    m2_6 <= sd5.m - y2_5;
    az_6 <= sd5.az;
    zpos_6 <= sd5.zpos;
    fail6 <= sd5.fail;

    dm <= mul_start(m2_6[127] ? -m2_6 : m2_6, wid_t'(az_6));
    gabs7 <= g6[127] ? -g6 : g6;
    fl7 <= '{fail: fail6, zero: 1'b0,
             nneg: (g6 != '0) && (g6[127] ^ zpos_6 ^ m2_6[127]), mneg: m2_6[127]};

    den8 <= 112'(mul_finish(dm));
    num8 <= gabs7[111:0];
    fl8 <= fl7;
  end

  // N1..N3: normalize both magnitudes below 2^30
  logic [111:0] o_c;
  logic [2:0] hc_c, hc9;
  logic [15:0] chk_c, chk9;
  logic [3:0] pos_c;
  logic [6:0] len_c, sh10;

  always_comb begin
    o_c = den8 | num8;
    hc_c = '0;
    for (int i = 0; i < 7; i++) begin
      if (o_c[16*i +: 16] != '0) hc_c = 3'(i);
    end
    chk_c = o_c[16*hc_c +: 16];
  end

  always_comb begin
    pos_c = '0;
    for (int i = 0; i < 16; i++) begin
      if (chk9[i]) pos_c = 4'(i);
    end
    len_c = {hc9, 4'b0000} + 7'(pos_c) + 7'd1;
  end

  logic signed [CW-1:0] cx [CORDIC_N+1];
  logic signed [CW-1:0] cy [CORDIC_N+1];
  ang_t                 ang [CORDIC_N+1];
  flag_t                cf [CORDIC_N+1];

  always_ff @(posedge clk) begin
    den9 <= den8;
    num9 <= num8;
    hc9 <= hc_c;
    chk9 <= chk_c;
    fl9 <= '{fail: fl8.fail, zero: (o_c == '0), nneg: fl8.nneg, mneg: fl8.mneg};

    den10 <= den9;
    num10 <= num9;
    sh10 <= (len_c > 7'd30) ? len_c - 7'd30 : '0;
    fl10 <= fl9;

    cx[0] <= $signed(CW'(den10 >> sh10));
    cy[0] <= $signed(CW'(num10 >> sh10));
    ang[0] <= '0;
    cf[0] <= fl10;
  end

  // CORDIC vectoring, one micro-rotation per stage
  for (genvar k = 0; k < CORDIC_N; k++) begin : g_cordic
    always_ff @(posedge clk) begin
      cf[k+1] <= cf[k];
      if (cy[k][CW-1]) begin
        cx[k+1] <= cx[k] - (cy[k] >>> k);
        cy[k+1] <= cy[k] + (cx[k] >>> k);
        ang[k+1] <= ang[k] - atan_step(k);
      end else begin
        cx[k+1] <= cx[k] + (cy[k] >>> k);
        cy[k+1] <= cy[k] - (cx[k] >>> k);
        ang[k+1] <= ang[k] + atan_step(k);
      end
    end
  end

  // quadrant fix, rounding, saturation
  ang_t a0, a1, a2, rnd;

  always_comb begin
    a0 = cf[CORDIC_N].zero ? '0 : ang[CORDIC_N];
    a1 = cf[CORDIC_N].nneg ? -a0 : a0;
    a2 = cf[CORDIC_N].mneg ? a1 + PI_ANG : a1;
    rnd = (a2 + ang_t'(1 <<< (RND_SH - 1))) >>> RND_SH;
  end

  always_ff @(posedge clk) begin
    if (rnd > 28'sd65535) begin
      angle <= 17'sd65535;
    end else if (rnd < -28'sd65536) begin
      angle <= -17'sd65536;
    end else begin
      angle <= 17'(rnd);
    end
    unreach <= cf[CORDIC_N].fail;
  end

endmodule

// ===== rtl/delta_robot_inverse_kinematics_top.sv =====
// Top level of the three-arm delta robot inverse kinematics block.
//
//  channel   ports                                         handshake
//  request   start, busy, pos_x, pos_y, pos_z              start & !busy
//  result    done, arm1..3_angle, status, failing_arm      done strobe, one cycle
//  config    psel, penable, pwrite, paddr, pwdata, prdata  APB, pready tied high
//
// One request per cycle while busy is low. busy is raised after reset and after each
// register write while the derived geometry terms settle.
// A result passes through the 52-stage square root and the 24-stage CORDIC in each arm.
// rst clears the valid pipeline and the registers to their defaults.
// Results cannot be held off, so the pipeline never stalls.
module delta_robot_inverse_kinematics_top #(
  parameter int ANGLE_FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] pos_z,
  output logic               done,
  output logic signed [16:0] arm1_angle,
  output logic signed [16:0] arm2_angle,
  output logic signed [16:0] arm3_angle,
  output logic [1:0]         status,
  output logic [1:0]         failing_arm,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import drik_pkg::*;

  localparam int LAT = 1 + LAT_ARM;
  localparam logic [1:0] CFG_SETTLE = 2'd2;

  logic [15:0] base_side, effector_side, upper_arm_length, forearm_length;
  logic [1:0] cfg_wait;

  assign pready = 1'b1;
  assign busy = (cfg_wait != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      base_side <= RST_BASE_SIDE;
      effector_side <= RST_EFFECTOR_SIDE;
      upper_arm_length <= RST_UPPER_ARM;
      forearm_length <= RST_FOREARM;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_BASE_SIDE:     base_side <= pwdata[15:0];
        REG_EFFECTOR_SIDE: effector_side <= pwdata[15:0];
        REG_UPPER_ARM:     upper_arm_length <= pwdata[15:0];
        REG_FOREARM:       forearm_length <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // hold off requests until the geometry terms carry the new register values
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_wait <= CFG_SETTLE;
    end else if (psel && penable && pwrite) begin
      cfg_wait <= CFG_SETTLE;
    end else if (cfg_wait != 2'd0) begin
      cfg_wait <= cfg_wait - 2'd1;
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_BASE_SIDE:     prdata = {16'h0000, base_side};
      REG_EFFECTOR_SIDE: prdata = {16'h0000, effector_side};
      REG_UPPER_ARM:     prdata = {16'h0000, upper_arm_length};
      REG_FOREARM:       prdata = {16'h0000, forearm_length};
      default:           prdata = '0;
    endcase
  end

  // geometry terms derived from the registers
  logic [47:0] pb1, pe1, r1, rr1, r2, rr2;
  crd_t y1_2, e2, y1_3, e3;
  nar_t y1sq3;
  cfg_k_t cfgk;

  always_ff @(posedge clk) begin
    pb1 <= {base_side, 8'h00} * HALF_TAN30_Q24;
    pe1 <= {effector_side, 8'h00} * HALF_TAN30_Q24;
    r1 <= {upper_arm_length, 8'h00} * {upper_arm_length, 8'h00};
    rr1 <= {forearm_length, 8'h00} * {forearm_length, 8'h00};

    y1_2 <= -crd_t'((pb1 + 48'd8388608) >> 24);
    e2 <= crd_t'((pe1 + 48'd8388608) >> 24);
    r2 <= r1;
    rr2 <= rr1;

    y1sq3 <= nar_t'(y1_2) * nar_t'(y1_2);
    y1_3 <= y1_2;
    e3 <= e2;

    cfgk.kc <= nar_t'(r2) - nar_t'(rr2) - y1sq3;
    cfgk.r4 <= nar_t'({r2, 2'b00});
    cfgk.y1 <= y1_3;
    cfgk.y1x2 <= y1_3 <<< 1;
    cfgk.e_off <= e3;
  end

  // front end: scale and rotate into the three arm frames
  crd_t x0, y0;
  nar_t xp0, yp0;
  crd_t xs_c, ys_c;
  crd_t fx0, fy0, fx1, fy1, fx2, fy2, z1;
  crd_t z0;

  always_ff @(posedge clk) begin
    x0 <= crd_t'($signed({pos_x, 8'h00}));
    y0 <= crd_t'($signed({pos_y, 8'h00}));
    z0 <= crd_t'($signed({pos_z, 8'h00}));
    xp0 <= nar_t'($signed({pos_x, 8'h00})) * nar_t'(SIN120_Q24);
    yp0 <= nar_t'($signed({pos_y, 8'h00})) * nar_t'(SIN120_Q24);
  end

  assign xs_c = crd_t'((xp0 + 64'sd8388608) >>> 24);
  assign ys_c = crd_t'((yp0 + 64'sd8388608) >>> 24);

  always_ff @(posedge clk) begin
    fx0 <= y0;
    fy0 <= -x0;
    fx1 <= -(y0 >>> 1) - xs_c;
    fy1 <= (x0 >>> 1) - ys_c;
    fx2 <= -(y0 >>> 1) + xs_c;
    fy2 <= (x0 >>> 1) + ys_c;
    z1 <= z0;
  end

  logic signed [16:0] ang_a [3];
  logic [2:0] unr;

  drik_arm #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_arm1 (
    .clk(clk), .xa_in(fx0), .ya_in(fy0), .z_in(z1), .cfg(cfgk),
    .angle(ang_a[0]), .unreach(unr[0])
  );

  drik_arm #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_arm2 (
    .clk(clk), .xa_in(fx1), .ya_in(fy1), .z_in(z1), .cfg(cfgk),
    .angle(ang_a[1]), .unreach(unr[1])
  );

  drik_arm #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_arm3 (
    .clk(clk), .xa_in(fx2), .ya_in(fy2), .z_in(z1), .cfg(cfgk),
    .angle(ang_a[2]), .unreach(unr[2])
  );

  // valid and zero-height flags ride alongside the arms
  logic [LAT:0] vld;
  logic [LAT:0] zh;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      done <= 1'b0;
    end else begin
      vld <= {vld[LAT-1:0], start && !busy};
      done <= vld[LAT];
    end
  end

  always_ff @(posedge clk) begin
    zh <= {zh[LAT-1:0], pos_z == 16'sd0};
    arm1_angle <= ang_a[0];
    arm2_angle <= ang_a[1];
    arm3_angle <= ang_a[2];
    status <= ST_OK;
    failing_arm <= 2'd0;
    if (zh[LAT]) begin
      arm1_angle <= '0;
      arm2_angle <= '0;
      arm3_angle <= '0;
      status <= ST_ZERO;
      failing_arm <= 2'd1;
    end else if (unr[0]) begin
      arm1_angle <= '0;
      arm2_angle <= '0;
      arm3_angle <= '0;
      status <= ST_UNREACH;
      failing_arm <= 2'd1;
    end else if (unr[1]) begin
      arm2_angle <= '0;
      arm3_angle <= '0;
      status <= ST_UNREACH;
      failing_arm <= 2'd2;
    end else if (unr[2]) begin
      arm3_angle <= '0;
      status <= ST_UNREACH;
      failing_arm <= 2'd3;
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(LAT + 2) done)
    else $error("result missing after pipeline latency");

  a_status_arm: assert property (@(posedge clk) disable iff (rst)
    done |-> ((status == ST_OK) == (failing_arm == 2'd0)))
    else $error("status and failing arm disagree");

  a_zero_height: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_ZERO) |->
      (failing_arm == 2'd1 && arm1_angle == '0 && arm2_angle == '0 && arm3_angle == '0))
    else $error("zero height result not cleared");

  a_later_arms: assert property (@(posedge clk) disable iff (rst)
    (done && failing_arm == 2'd2) |-> (arm2_angle == '0 && arm3_angle == '0))
    else $error("arms after the failing arm not cleared");

endmodule

// ===== dv/delta_robot_inverse_kinematics_top_test.sv =====
// Self-checking testbench for the delta robot inverse kinematics top level.
module delta_robot_inverse_kinematics_top_test;
  import drik_pkg::*;

  typedef logic signed [127:0] w128;

  typedef struct {
    logic signed [16:0] a1;
    logic signed [16:0] a2;
    logic signed [16:0] a3;
    logic [1:0] st;
    logic [1:0] fail;
  } angles_t;

  localparam int FRAC = 14;
  localparam longint SIN120 = 64'sd14529495;
  localparam longint HTAN30 = 64'sd4843165;
  localparam longint PI_A = 64'sd52707179;
  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [15:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic busy, done, pready;
  logic signed [16:0] arm1_angle, arm2_angle, arm3_angle;
  logic [1:0] status, failing_arm;
  logic [31:0] prdata;

  longint geo [4];
  angles_t pending_angles[$];
  int errors = 0;
  int cycles = 0;

  delta_robot_inverse_kinematics_top #(.ANGLE_FRAC_BITS(FRAC)) DUT (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("** delta_robot_inverse_kinematics_top: FAILED **");
      $finish;
    end
  end

  function automatic longint rnd_shr(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint cordic_atan(logic [127:0] yy, logic [127:0] xx);
    longint cx, cy, dx, dy, ang;
    logic [27:0] stp;
    ang = 0;
    if (xx == 0 && yy == 0) return 0;
    while (xx >= (128'd1 << 30) || yy >= (128'd1 << 30)) begin
      xx = xx >> 1;
      yy = yy >> 1;
    end
    cx = longint'(xx[63:0]);
    cy = longint'(yy[63:0]);
    for (int i = 0; i < 24; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      stp = atan_step(i);
      if (cy >= 0) begin
        cx += dx; cy -= dy; ang += longint'(stp);
      end else begin
        cx -= dx; cy += dy; ang -= longint'(stp);
      end
    end
    return ang;
  endfunction

  // one arm in its own frame; returns status code, angle through theta
  function automatic logic [1:0] arm_solve(longint xa, longint ya, longint zz,
                                            output longint theta);
    longint y1, r, rr, s, u, q, p2, az, ang;
    logic [63:0] root, c;
    logic [127:0] cc;
    w128 d4, sqw, y2, g, m2, den, num;
    logic mneg;
    theta = 0;
    if (zz == 0) return ST_ZERO;
    y1 = -rnd_shr((geo[REG_BASE_SIDE] <<< 8) * HTAN30, 24);
    ya -= rnd_shr((geo[REG_EFFECTOR_SIDE] <<< 8) * HTAN30, 24);
    r = geo[REG_UPPER_ARM] <<< 8;
    rr = geo[REG_FOREARM] <<< 8;
    s = xa * xa + ya * ya + zz * zz + r * r - rr * rr - y1 * y1;
    u = y1 - ya;
    q = u * u + zz * zz;
    p2 = s + 2 * u * y1;
    d4 = w128'(4 * r * r) * w128'(q) - w128'(p2) * w128'(p2);
    if (d4 < 0) return ST_UNREACH;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      c = root | (64'd1 << b);
      cc = {64'b0, c} * {64'b0, c};
      if (cc <= 128'(d4)) root = c;
    end
    sqw = {64'b0, root};
    az = zz < 0 ? -zz : zz;
    y2 = w128'(2 * y1) * w128'(zz * zz) - w128'(s) * w128'(u) - w128'(az) * sqw;
    g = w128'(s) * w128'(q) + y2 * w128'(u);
    m2 = w128'(2 * y1) * w128'(q) - y2;
    mneg = m2 < 0;
    den = (mneg ? -m2 : m2) * w128'(az);
    num = g;
    if (zz > 0) num = -num;
    if (mneg) num = -num;
    ang = cordic_atan(num < 0 ? -num : num, den);
    if (num < 0) ang = -ang;
    if (mneg) ang += PI_A;
    ang = rnd_shr(ang, 24 - FRAC);
    if (ang > 65535) ang = 65535;
    if (ang < -65536) ang = -65536;
    theta = ang;
    return ST_OK;
  endfunction

  function automatic angles_t predict_angles(logic signed [15:0] px, logic signed [15:0] py,
                                             logic signed [15:0] pz);
    longint x, y, z, xs, ys;
    longint fx [3], fy [3], th [3];
    logic [1:0] code;
    angles_t e;
    x = longint'(px) * 256;
    y = longint'(py) * 256;
    z = longint'(pz) * 256;
    xs = rnd_shr(x * SIN120, 24);
    ys = rnd_shr(y * SIN120, 24);
    fx[0] = y;            fy[0] = -x;
    fx[1] = -y / 2 - xs;  fy[1] = x / 2 - ys;
    fx[2] = -y / 2 + xs;  fy[2] = x / 2 + ys;
    th = '{0, 0, 0};
    e.st = ST_OK;
    e.fail = 2'd0;
    for (int k = 0; k < 3; k++) begin
      if (e.st == ST_OK) begin
        code = arm_solve(fx[k], fy[k], z, th[k]);
        if (code != ST_OK) begin
          e.st = code;
          e.fail = 2'(k + 1);
          th[k] = 0;
        end
      end
    end
    e.a1 = th[0][16:0];
    e.a2 = th[1][16:0];
    e.a3 = th[2][16:0];
    return e;
  endfunction

  always @(posedge clk) begin
    angles_t e;
    if (!rst && done) begin
      if (pending_angles.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        e = pending_angles.pop_front();
        if (arm1_angle !== e.a1) begin
          $error("arm1_angle exp %0d got %0d", e.a1, arm1_angle); errors++;
        end
        if (arm2_angle !== e.a2) begin
          $error("arm2_angle exp %0d got %0d", e.a2, arm2_angle); errors++;
        end
        if (arm3_angle !== e.a3) begin
          $error("arm3_angle exp %0d got %0d", e.a3, arm3_angle); errors++;
        end
        if (status !== e.st) begin
          $error("status exp %0d got %0d", e.st, status); errors++;
        end
        if (failing_arm !== e.fail) begin
          $error("failing_arm exp %0d got %0d", e.fail, failing_arm); errors++;
        end
      end
    end
  end

  task automatic send_pos(logic signed [15:0] px, logic signed [15:0] py,
                          logic signed [15:0] pz);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    pos_x <= px;
    pos_y <= py;
    pos_z <= pz;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_angles = {pending_angles, predict_angles(px, py, pz)};
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_geometry(logic [1:0] idx, logic [15:0] val);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 4'(idx) << 2;
    pwdata <= {16'b0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    geo[idx] = longint'(val);
  endtask

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 7)
        send_pos(16'($signed($urandom_range(0, 3200)) - 1600),
                 16'($signed($urandom_range(0, 3200)) - 1600),
                 16'(-$signed($urandom_range(1000, 6000))));
      else
        send_pos(16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic test_directed;
    send_pos(16'sd0, 16'sd0, -16'sd3500);
    send_pos(16'sd0, 16'sd0, 16'sd0);
    send_pos(16'sd500, -16'sd300, 16'sd0);
    send_pos(16'sd0, 16'sd0, 16'sd3500);
    send_pos(16'sd0, 16'sd0, -16'sd32768);
    send_pos(16'sd32767, 16'sd0, -16'sd3000);
    send_pos(-16'sd32768, 16'sd0, -16'sd3000);
    send_pos(16'sd0, 16'sd32767, -16'sd3000);
    send_pos(16'sd0, -16'sd32768, -16'sd3000);
    send_pos(16'sd32767, 16'sd32767, 16'sd32767);
    send_pos(-16'sd32768, -16'sd32768, -16'sd32768);
    send_pos(16'sd1500, 16'sd0, -16'sd4000);
    send_pos(-16'sd1500, 16'sd800, -16'sd4000);
    send_pos(16'sd0, 16'sd2000, -16'sd2000);
    send_pos(16'sd0, 16'sd0, -16'sd1);
    send_pos(16'sd0, 16'sd0, 16'sd1);
    send_pos(16'sd1000, 16'sd1000, -16'sd5400);
    send_pos(-16'sd1, -16'sd1, -16'sd3000);
  endtask

  task automatic test_reset_geometry;
    send_random(500);
  endtask

  task automatic test_drain_pause;
    send_random(40);
    drain();
    send_random(40);
  endtask

  task automatic test_geometry_sweep;
    write_geometry(REG_BASE_SIDE, 16'd65535);
    write_geometry(REG_EFFECTOR_SIDE, 16'd1);
    send_random(80);
    write_geometry(REG_UPPER_ARM, 16'd65535);
    write_geometry(REG_FOREARM, 16'd65535);
    send_random(80);
    write_geometry(REG_BASE_SIDE, 16'd1);
    write_geometry(REG_EFFECTOR_SIDE, 16'd65535);
    write_geometry(REG_UPPER_ARM, 16'd1);
    write_geometry(REG_FOREARM, 16'd1);
    send_random(80);
    write_geometry(REG_BASE_SIDE, 16'd4001);
    write_geometry(REG_EFFECTOR_SIDE, 16'd903);
    write_geometry(REG_UPPER_ARM, 16'd2500);
    write_geometry(REG_FOREARM, 16'd5001);
    send_random(120);
    write_geometry(REG_BASE_SIDE, RST_BASE_SIDE);
    write_geometry(REG_EFFECTOR_SIDE, RST_EFFECTOR_SIDE);
    write_geometry(REG_UPPER_ARM, RST_UPPER_ARM);
    write_geometry(REG_FOREARM, RST_FOREARM);
    send_random(100);
  endtask

  initial begin
    geo[REG_BASE_SIDE] = longint'(RST_BASE_SIDE);
    geo[REG_EFFECTOR_SIDE] = longint'(RST_EFFECTOR_SIDE);
    geo[REG_UPPER_ARM] = longint'(RST_UPPER_ARM);
    geo[REG_FOREARM] = longint'(RST_FOREARM);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_reset_geometry();
    test_drain_pause();
    test_geometry_sweep();
    drain();
    repeat (120) @(posedge clk);
    if (errors == 0)
      $display("** delta_robot_inverse_kinematics_top: PASSED **");
    else
      $display("** delta_robot_inverse_kinematics_top: FAILED **");
    $finish;
  end

endmodule
